/* hw/rtl/gssc_pkg.sv */
package gssc_pkg;

	localparam int ITER_W     = 16;
	localparam int SHARE_W    = 16;
	localparam int TOTAL_W    = 20;
	localparam int DIVIDEND_W = 24;
	localparam int DIVISOR_W  = 20;
	localparam int DIV_CNT_W  = 5;
	localparam int UPC_W      = 5;

	localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DIVIDEND_W);
	localparam logic [SHARE_W-1:0]   ONE_Q8    = 16'h0100;

	localparam logic [1:0] CFG_TOTAL_ITERATIONS = 2'd0;
	localparam logic [1:0] CFG_MIN_CHUNK        = 2'd1;
	localparam logic [1:0] CFG_USE_LOAD         = 2'd2;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_TOTAL_ZERO = 2'd1,
		ST_SHARE_LOW  = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_DIV_LOAD,
		OP_REG_WRITE,
		OP_REQ_INIT,
		OP_DIV_PIECE,
		OP_PIECE,
		OP_COMMIT,
		OP_ERR_TOTAL,
		OP_ERR_SHARE,
		OP_EMIT
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_MODE_REQ,
		C_ID_BAD,
		C_NO_LOAD,
		C_DIV_BUSY,
		C_TOTAL_ZERO,
		C_SHARE_BAD,
		C_REM_ZERO,
		C_MORE_ROUNDS,
		C_OUT_FULL
	} cond_t;

	typedef logic [UPC_W-1:0] upc_t;

	typedef struct packed {
		logic  in_ready;
		op_t   op;
		cond_t cond;
		upc_t  target;
	} ctrl_t;

	typedef struct packed {
		logic mode_req;
		logic id_bad;
		logic no_load;
		logic div_busy;
		logic total_zero;
		logic share_bad;
		logic rem_zero;
		logic more_rounds;
		logic out_full;
	} flags_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	// Microprogram addresses.
	localparam upc_t U_IDLE          = 5'd0;
	localparam upc_t U_DISPATCH      = 5'd1;
	localparam upc_t U_REG_CHECK     = 5'd2;
	localparam upc_t U_LOAD_CHECK    = 5'd3;
	localparam upc_t U_DIV_LOAD      = 5'd4;
	localparam upc_t U_DIV_LOAD_WAIT = 5'd5;
	localparam upc_t U_REG_WRITE     = 5'd6;
	localparam upc_t U_REQ           = 5'd7;
	localparam upc_t U_SHARE_CHECK   = 5'd8;
	localparam upc_t U_REQ_INIT      = 5'd9;
	localparam upc_t U_ROUND         = 5'd10;
	localparam upc_t U_DIV_PIECE     = 5'd11;
	localparam upc_t U_PIECE_WAIT    = 5'd12;
	localparam upc_t U_PIECE         = 5'd13;
	localparam upc_t U_COMMIT        = 5'd14;
	localparam upc_t U_OUT_WAIT      = 5'd15;
	localparam upc_t U_EMIT          = 5'd16;
	localparam upc_t U_ERR_TOTAL     = 5'd17;
	localparam upc_t U_ERR_SHARE     = 5'd18;

	function automatic ctrl_t cw(input logic rdy, input op_t op, input cond_t cond,
		input upc_t target);
		ctrl_t w;
		w.in_ready = rdy;
		w.op       = op;
		w.cond     = cond;
		w.target   = target;
		return w;
	endfunction

	function automatic ctrl_t ucode_rom(input upc_t addr);
		ctrl_t w;
		case (addr)
			U_IDLE:          w = cw(1'b1, OP_NOP,       C_NO_INPUT,    U_IDLE);
			U_DISPATCH:      w = cw(1'b0, OP_NOP,       C_MODE_REQ,    U_REQ);
			U_REG_CHECK:     w = cw(1'b0, OP_NOP,       C_ID_BAD,      U_IDLE);
			U_LOAD_CHECK:    w = cw(1'b0, OP_NOP,       C_NO_LOAD,     U_REG_WRITE);
			U_DIV_LOAD:      w = cw(1'b0, OP_DIV_LOAD,  C_NEVER,       U_IDLE);
			U_DIV_LOAD_WAIT: w = cw(1'b0, OP_NOP,       C_DIV_BUSY,    U_DIV_LOAD_WAIT);
			U_REG_WRITE:     w = cw(1'b0, OP_REG_WRITE, C_ALWAYS,      U_IDLE);
			U_REQ:           w = cw(1'b0, OP_NOP,       C_TOTAL_ZERO,  U_ERR_TOTAL);
			U_SHARE_CHECK:   w = cw(1'b0, OP_NOP,       C_SHARE_BAD,   U_ERR_SHARE);
			U_REQ_INIT:      w = cw(1'b0, OP_REQ_INIT,  C_NEVER,       U_IDLE);
			U_ROUND:         w = cw(1'b0, OP_NOP,       C_REM_ZERO,    U_COMMIT);
			U_DIV_PIECE:     w = cw(1'b0, OP_DIV_PIECE, C_NEVER,       U_IDLE);
			U_PIECE_WAIT:    w = cw(1'b0, OP_NOP,       C_DIV_BUSY,    U_PIECE_WAIT);
			U_PIECE:         w = cw(1'b0, OP_PIECE,     C_MORE_ROUNDS, U_ROUND);
			U_COMMIT:        w = cw(1'b0, OP_COMMIT,    C_NEVER,       U_IDLE);
			U_OUT_WAIT:      w = cw(1'b0, OP_NOP,       C_OUT_FULL,    U_OUT_WAIT);
			U_EMIT:          w = cw(1'b0, OP_EMIT,      C_ALWAYS,      U_IDLE);
			U_ERR_TOTAL:     w = cw(1'b0, OP_ERR_TOTAL, C_ALWAYS,      U_OUT_WAIT);
			U_ERR_SHARE:     w = cw(1'b0, OP_ERR_SHARE, C_ALWAYS,      U_OUT_WAIT);
			default:         w = cw(1'b0, OP_NOP,       C_ALWAYS,      U_IDLE);
		endcase
		return w;
	endfunction

endpackage

/* hw/rtl/gssc_div.sv */
module gssc_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  gssc_pkg::div_req_t                  req,
	output logic                                busy,
	output logic [gssc_pkg::DIVIDEND_W-1:0]     quot,
	output logic [gssc_pkg::DIVISOR_W-1:0]      rem
);

	logic [gssc_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [gssc_pkg::DIVIDEND_W-1:0] work_q;
	logic [gssc_pkg::DIVISOR_W-1:0]  rem_q;
	logic [gssc_pkg::DIVISOR_W-1:0]  dvs_q;
	logic [gssc_pkg::DIVISOR_W:0]    shifted;
	logic [gssc_pkg::DIVISOR_W:0]    diff;
	logic                            fits;

	// Restoring division, one quotient bit per cycle; the quotient shifts
	// into the dividend register as the dividend bits shift out.
	assign shifted = {rem_q, work_q[gssc_pkg::DIVIDEND_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign fits    = shifted >= {1'b0, dvs_q};
	assign busy    = cnt_q != '0;
	assign quot    = work_q;
	assign rem     = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= gssc_pkg::DIV_STEPS;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			work_q <= req.dividend;
			rem_q  <= '0;
			dvs_q  <= req.divisor;
		end else if (busy) begin
			work_q <= {work_q[gssc_pkg::DIVIDEND_W-2:0], fits};
			rem_q  <= fits ? diff[gssc_pkg::DIVISOR_W-1:0]
				: shifted[gssc_pkg::DIVISOR_W-1:0];
		end
	end

endmodule

/* hw/rtl/gssc_seq.sv */
module gssc_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  gssc_pkg::flags_t  flags,
	output gssc_pkg::ctrl_t   ctrl
);

	gssc_pkg::upc_t upc_q;
	logic           take;

	assign ctrl = gssc_pkg::ucode_rom(upc_q);

	always_comb begin
		unique case (ctrl.cond)
			gssc_pkg::C_NEVER:       take = 1'b0;
			gssc_pkg::C_ALWAYS:      take = 1'b1;
			gssc_pkg::C_NO_INPUT:    take = !in_valid;
			gssc_pkg::C_MODE_REQ:    take = flags.mode_req;
			gssc_pkg::C_ID_BAD:      take = flags.id_bad;
			gssc_pkg::C_NO_LOAD:     take = flags.no_load;
			gssc_pkg::C_DIV_BUSY:    take = flags.div_busy;
			gssc_pkg::C_TOTAL_ZERO:  take = flags.total_zero;
			gssc_pkg::C_SHARE_BAD:   take = flags.share_bad;
			gssc_pkg::C_REM_ZERO:    take = flags.rem_zero;
			gssc_pkg::C_MORE_ROUNDS: take = flags.more_rounds;
			gssc_pkg::C_OUT_FULL:    take = flags.out_full;
			default:                 take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= gssc_pkg::U_IDLE;
		end else begin
			upc_q <= take ? ctrl.target : upc_q + 1'b1;
		end
	end

endmodule

/* hw/rtl/gssc_dp.sv */
module gssc_dp #(
	parameter int MAX_WORKERS      = 16,
	parameter int MAX_SHARE_ROUNDS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gssc_pkg::ctrl_t   ctrl,
	output gssc_pkg::flags_t  flags,
	input  logic              in_valid,
	input  logic              mode,
	input  logic [3:0]        worker_id,
	input  logic [15:0]       worker_power,
	input  logic [7:0]        worker_load,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [15:0]       chunk_start,
	output logic [15:0]       chunk_size,
	output logic [1:0]        status,
	output logic [15:0]       steps_total,
	output logic [15:0]       steps_at_minimum,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int RND_W = $clog2(MAX_SHARE_ROUNDS + 1);

	// Configuration.
	logic [15:0] total_iterations_q;
	logic [15:0] min_chunk_q;
	logic        use_load_q;

	// Item registers.
	logic        mode_q;
	logic [3:0]  id_q;
	logic [15:0] power_q;
	logic [7:0]  load_q;

	// Share table.
	logic [gssc_pkg::SHARE_W-1:0] share_mem [MAX_WORKERS];
	logic [MAX_WORKERS-1:0]       valid_q;
	logic [gssc_pkg::SHARE_W-1:0] rd_data_q;
	logic                         rd_valid_q;
	logic [gssc_pkg::SHARE_W-1:0] share_rd;

	logic [IDX_W+3:0] id_in_ext;
	logic [IDX_W+3:0] id_q_ext;
	logic [IDX_W-1:0] raddr;
	logic [IDX_W-1:0] waddr;
	logic             in_range_in;
	logic             in_range_q;

	// Scheduler state.
	logic [gssc_pkg::TOTAL_W-1:0] total_share_q;
	logic [15:0]                  assigned_q;
	logic [15:0]                  nonzero_q;
	logic [15:0]                  minimum_q;

	// Work registers of one request.
	logic [15:0]           remaining_q;
	logic [15:0]           size_q;
	logic [15:0]           start_q;
	logic [RND_W-1:0]      rounds_q;
	gssc_pkg::status_t     status_q;
	gssc_pkg::status_t     out_status_q;
	logic                  out_valid_q;

	// Divider.
	gssc_pkg::div_req_t                 div_req;
	logic                               div_busy;
	logic [gssc_pkg::DIVIDEND_W-1:0]    div_quot;
	logic [gssc_pkg::DIVISOR_W-1:0]     div_rem;

	logic                                accept;
	logic [gssc_pkg::SHARE_W-1:0]        share_new;
	logic [7:0]                          load_eff;
	logic [gssc_pkg::DIVIDEND_W-1:0]     need;
	logic [gssc_pkg::DIVIDEND_W-1:0]     min_ext;
	logic [gssc_pkg::DIVIDEND_W-1:0]     cand;
	logic                                take_cand;
	logic                                clamp;
	logic [15:0]                         piece;
	logic [RND_W-1:0]                    rounds_init;

	assign accept    = in_valid && ctrl.in_ready;
	assign cfg_ready = 1'b1;

	assign id_in_ext   = {{IDX_W{1'b0}}, worker_id};
	assign id_q_ext    = {{IDX_W{1'b0}}, id_q};
	assign raddr       = id_in_ext[IDX_W-1:0];
	assign waddr       = id_q_ext[IDX_W-1:0];
	assign in_range_in = id_in_ext < (IDX_W+4)'(MAX_WORKERS);
	assign in_range_q  = id_q_ext < (IDX_W+4)'(MAX_WORKERS);

	// An entry that was never written reads as a zero share.
	assign share_rd = rd_valid_q ? rd_data_q : '0;

	assign load_eff  = (load_q == '0) ? 8'd1 : load_q;
	assign share_new = use_load_q ? div_quot[gssc_pkg::SHARE_W-1:0] : gssc_pkg::ONE_Q8;

	// Piece of one round: ceil(remaining * 256 / total), at least the minimum,
	// at most what remains.
	assign need      = div_quot + gssc_pkg::DIVIDEND_W'(div_rem != '0);
	assign min_ext   = {8'd0, min_chunk_q};
	assign cand      = (need > min_ext) ? need : min_ext;
	assign take_cand = {8'd0, remaining_q} > cand;
	assign clamp     = take_cand && (cand == min_ext);
	assign piece     = take_cand ? cand[15:0] : remaining_q;

	assign rounds_init = !use_load_q ? RND_W'(1)
		: (share_rd[15:8] > 8'(MAX_SHARE_ROUNDS)) ? RND_W'(MAX_SHARE_ROUNDS)
		: RND_W'(share_rd[15:8]);

	always_comb begin
		div_req.start    = (ctrl.op == gssc_pkg::OP_DIV_LOAD)
			|| (ctrl.op == gssc_pkg::OP_DIV_PIECE);
		div_req.dividend = (ctrl.op == gssc_pkg::OP_DIV_LOAD)
			? {8'd0, power_q} : {remaining_q, 8'd0};
		div_req.divisor  = (ctrl.op == gssc_pkg::OP_DIV_LOAD)
			? {12'd0, load_eff} : total_share_q;
	end

	gssc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.busy   (div_busy),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	always_comb begin
		flags.mode_req    = mode_q;
		flags.id_bad      = !in_range_q;
		flags.no_load     = !use_load_q;
		flags.div_busy    = div_busy;
		flags.total_zero  = total_share_q == '0;
		flags.share_bad   = !in_range_q || (share_rd[15:8] == '0);
		flags.rem_zero    = remaining_q == '0;
		flags.more_rounds = rounds_q != RND_W'(1);
		flags.out_full    = out_valid_q && !out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_iterations_q <= '0;
			min_chunk_q        <= 16'd1;
			use_load_q         <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gssc_pkg::CFG_TOTAL_ITERATIONS: total_iterations_q <= cfg_data;
				gssc_pkg::CFG_MIN_CHUNK:        min_chunk_q        <= cfg_data;
				gssc_pkg::CFG_USE_LOAD:         use_load_q         <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Share memory with registered read at the accepted worker id.
	always_ff @(posedge clk) begin
		if (ctrl.op == gssc_pkg::OP_REG_WRITE) begin
			share_mem[waddr] <= share_new;
		end
		if (accept) begin
			rd_data_q <= share_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (ctrl.op == gssc_pkg::OP_REG_WRITE) begin
				valid_q[waddr] <= 1'b1;
			end
			if (accept) begin
				rd_valid_q <= in_range_in && valid_q[raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode;
			id_q    <= worker_id;
			power_q <= worker_power;
			load_q  <= worker_load;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_share_q <= '0;
			assigned_q    <= '0;
			nonzero_q     <= '0;
			minimum_q     <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (ctrl.op == gssc_pkg::OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (ctrl.op)
				gssc_pkg::OP_REG_WRITE: begin
					total_share_q <= total_share_q - {4'd0, share_rd} + {4'd0, share_new};
				end
				gssc_pkg::OP_PIECE: begin
					if (clamp) begin
						minimum_q <= minimum_q + 1'b1;
					end
				end
				gssc_pkg::OP_COMMIT: begin
					assigned_q <= assigned_q + size_q;
					if (size_q != '0) begin
						nonzero_q <= nonzero_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			gssc_pkg::OP_REQ_INIT: begin
				remaining_q <= (total_iterations_q > assigned_q)
					? total_iterations_q - assigned_q : '0;
				size_q      <= '0;
				start_q     <= assigned_q;
				rounds_q    <= rounds_init;
			end
			gssc_pkg::OP_PIECE: begin
				remaining_q <= remaining_q - piece;
				size_q      <= size_q + piece;
				rounds_q    <= rounds_q - 1'b1;
			end
			gssc_pkg::OP_COMMIT: begin
				status_q <= gssc_pkg::ST_OK;
			end
			gssc_pkg::OP_ERR_TOTAL: begin
				start_q  <= '0;
				size_q   <= '0;
				status_q <= gssc_pkg::ST_TOTAL_ZERO;
			end
			gssc_pkg::OP_ERR_SHARE: begin
				start_q  <= '0;
				size_q   <= '0;
				status_q <= gssc_pkg::ST_SHARE_LOW;
			end
			gssc_pkg::OP_EMIT: begin
				chunk_start      <= start_q;
				chunk_size       <= size_q;
				out_status_q     <= status_q;
				steps_total      <= nonzero_q;
				steps_at_minimum <= minimum_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;

endmodule

/* hw/rtl/guided_self_scheduling_chunker.sv */
// Guided self-scheduling chunk scheduler. A register transaction (mode 0) stores a
// worker's Q8.8 share (power / load in load-aware mode, else 1.0) and produces no
// result; a request transaction (mode 1) returns one result with the chunk's start,
// size, status and the two step counters. Control is a microprogram stepping a small
// datapath around a shared restoring divider that retires one quotient bit per cycle.
// A register transaction uses the divider only in load-aware mode. A request runs
// one share round in plain mode and up to MAX_SHARE_ROUNDS in load-aware mode, each
// with a divide, plus any wait for the previous result to be taken. Configuration is
// written through the cfg channel, which is always ready; the user must write it only
// while the block is idle, as the block itself does not enforce this.
module guided_self_scheduling_chunker #(
	parameter int MAX_WORKERS      = 16,
	parameter int MAX_SHARE_ROUNDS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [3:0]  worker_id,
	input  logic [15:0] worker_power,
	input  logic [7:0]  worker_load,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] chunk_start,
	output logic [15:0] chunk_size,
	output logic [1:0]  status,
	output logic [15:0] steps_total,
	output logic [15:0] steps_at_minimum,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	gssc_pkg::ctrl_t  ctrl;
	gssc_pkg::flags_t flags;

	assign in_ready = ctrl.in_ready;

	gssc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.flags    (flags),
		.ctrl     (ctrl)
	);

	gssc_dp #(
		.MAX_WORKERS      (MAX_WORKERS),
		.MAX_SHARE_ROUNDS (MAX_SHARE_ROUNDS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctrl             (ctrl),
		.flags            (flags),
		.in_valid         (in_valid),
		.mode             (mode),
		.worker_id        (worker_id),
		.worker_power     (worker_power),
		.worker_load      (worker_load),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.chunk_start      (chunk_start),
		.chunk_size       (chunk_size),
		.status           (status),
		.steps_total      (steps_total),
		.steps_at_minimum (steps_at_minimum),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

endmodule

/* hw/rtl/gssc_checker.sv */
module gssc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] chunk_start,
	input logic [15:0] chunk_size,
	input logic [1:0]  status
);

	// A result held back by the consumer keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(chunk_start)
		&& $stable(chunk_size) && $stable(status))
		else $error("result changed while stalled");

	// A failed request hands out nothing.
	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != gssc_pkg::ST_OK) |-> (chunk_size == '0)
		&& (chunk_start == '0))
		else $error("error result carries a chunk");

	// The sequencer never accepts input on consecutive cycles.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on consecutive cycles");

endmodule

bind guided_self_scheduling_chunker gssc_checker u_checker (.*);

/* test/chunk_grant_checker.sv */
`timescale 1ns / 100ps

module chunk_grant_checker
	import gssc_pkg::*;
#(
	parameter int WORKERS   = 16,
	parameter int ROUND_CAP = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        mode,
	input  logic [3:0]  worker_id,
	input  logic [15:0] worker_power,
	input  logic [7:0]  worker_load,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] chunk_start,
	input  logic [15:0] chunk_size,
	input  logic [1:0]  status,
	input  logic [15:0] steps_total,
	input  logic [15:0] steps_at_minimum,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          outstanding,
	output int          results_seen,
	output logic [15:0] handed_out
);

	localparam logic MODE_ENROLL  = 1'b0;
	localparam logic MODE_REQUEST = 1'b1;

	typedef struct packed {
		logic [15:0] start;
		logic [15:0] size;
		status_t     status;
		logic [15:0] steps;
		logic [15:0] min_steps;
	} grant_t;

	grant_t      expected_grants[$];

	logic [15:0] share_of [WORKERS];
	logic [19:0] share_sum;
	logic [15:0] handed;
	logic [15:0] granted_steps;
	logic [15:0] floor_steps;
	logic [15:0] iter_limit;
	logic [15:0] chunk_floor;
	logic        load_aware;

	task automatic enroll(input logic [3:0] id, input logic [15:0] power,
		input logic [7:0] load);
		logic [15:0] share;
		logic [7:0]  divisor;
		divisor = (load == 8'd0) ? 8'd1 : load;
		share = load_aware ? power / divisor : ONE_Q8;
		share_sum = share_sum - 20'(share_of[id]) + 20'(share);
		share_of[id] = share;
	endtask

	task automatic grant(input logic [3:0] id);
		grant_t      g;
		logic [31:0] left;
		logic [31:0] need;
		logic [31:0] cand;
		logic [31:0] piece;
		logic [31:0] rounds;
		int          r;
		g = '0;
		if (share_sum == 20'd0) begin
			g.status = ST_TOTAL_ZERO;
		end else if (share_of[id] < ONE_Q8) begin
			g.status = ST_SHARE_LOW;
		end else begin
			g.status = ST_OK;
			left = (iter_limit > handed) ? 32'(iter_limit - handed) : 32'd0;
			rounds = 32'd1;
			if (load_aware) begin
				rounds = 32'(share_of[id] >> 8);
				if (rounds > ROUND_CAP)
					rounds = ROUND_CAP;
			end
			g.start = handed;
			// Each round hands out ceil(left / total share), widened to the floor and capped at what is left.
			for (r = 0; r < rounds && left != 0; r++) begin
				need = (left * 32'd256 + 32'(share_sum) - 32'd1) / 32'(share_sum);
				cand = (need > 32'(chunk_floor)) ? need : 32'(chunk_floor);
				if (left > cand) begin
					if (cand == 32'(chunk_floor))
						floor_steps++;
					piece = cand;
				end else begin
					piece = left;
				end
				left -= piece;
				g.size += 16'(piece);
			end
			handed += g.size;
			if (g.size != 16'd0)
				granted_steps++;
		end
		g.steps = granted_steps;
		g.min_steps = floor_steps;
		expected_grants.push_back(g);
	endtask

	task automatic compare_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		grant_t oldest;
		if (!arst_n) begin
			expected_grants.delete();
			for (int i = 0; i < WORKERS; i++)
				share_of[i] = '0;
			share_sum = '0;
			handed = '0;
			granted_steps = '0;
			floor_steps = '0;
			iter_limit = 16'd0;
			chunk_floor = 16'd1;
			load_aware = 1'b0;
			mismatches = 0;
			results_seen = 0;
		end else begin
			// Results leave before new requests enter, so pop before pushing.
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_grants.size() == 0) begin
					$error("result with no request pending: chunk_start %0d, chunk_size %0d",
						chunk_start, chunk_size);
					mismatches++;
				end else begin
					oldest = expected_grants.pop_front();
					compare_field("chunk_start", oldest.start, chunk_start);
					compare_field("chunk_size", oldest.size, chunk_size);
					compare_field("status", oldest.status, status);
					compare_field("steps_total", oldest.steps, steps_total);
					compare_field("steps_at_minimum", oldest.min_steps, steps_at_minimum);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TOTAL_ITERATIONS: iter_limit = cfg_data;
					CFG_MIN_CHUNK:        chunk_floor = cfg_data;
					CFG_USE_LOAD:         load_aware = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (mode == MODE_REQUEST)
					grant(worker_id);
				else
					enroll(worker_id, worker_power, worker_load);
			end
		end
		outstanding = expected_grants.size();
		handed_out = handed;
	end

endmodule

/* test/tb_guided_self_scheduling_chunker.sv */
`timescale 1ns / 100ps

module tb_guided_self_scheduling_chunker;
	import gssc_pkg::*;

	localparam logic MODE_ENROLL  = 1'b0;
	localparam logic MODE_REQUEST = 1'b1;

	localparam int ITEM_TARGET  = 1850;
	localparam int STALL_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 48;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        mode;
	logic [3:0]  worker_id;
	logic [15:0] worker_power;
	logic [7:0]  worker_load;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] chunk_start;
	logic [15:0] chunk_size;
	logic [1:0]  status;
	logic [15:0] steps_total;
	logic [15:0] steps_at_minimum;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	int          mismatches;
	int          outstanding;
	int          results_seen;
	logic [15:0] handed_out;

	bit          calm;
	bit          enrolled [16];
	int          idle_cycles;
	int          sent;
	int          requests_sent;
	int          phases;

	guided_self_scheduling_chunker dut (.*);

	chunk_grant_checker grant_check (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("No transaction for %0d cycles, %0d results still pending",
				idle_cycles, outstanding);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Result side: a random stall before each result, none in calm phases.
	initial begin : result_sink
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 5);
			if (stall > 0) begin
				@(negedge clk) out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk) out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	task automatic push_item(input logic m, input logic [3:0] id, input logic [15:0] power,
		input logic [7:0] load);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		worker_id <= id;
		worker_power <= power;
		worker_load <= load;
		do @(posedge clk); while (!in_ready);
		sent++;
		if (m == MODE_REQUEST)
			requests_sent++;
		else
			enrolled[id] = 1'b1;
	endtask

	// Register transactions give no result, so the last one may still be in
	// flight when the queue empties; the extra cycles cover a load-aware divide.
	task automatic settle();
		@(negedge clk) in_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic enroll_random();
		logic [3:0]  id;
		logic [7:0]  load;
		logic [15:0] power;
		int          eff;
		id = 4'($urandom_range(0, 15));
		load = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
			8'($urandom_range(0, 6));
		eff = (load == 8'd0) ? 1 : load;
		// Some powers land right at a share of one or just below it.
		if ($urandom_range(0, 3) == 0)
			power = 16'(eff * 256 - 1 + $urandom_range(0, 1));
		else
			power = 16'($urandom_range(0, 65535));
		push_item(MODE_ENROLL, id, power, load);
	endtask

	task automatic request_random();
		logic [3:0] id;
		id = 4'($urandom_range(0, 15));
		if ($urandom_range(0, 4) != 0)
			repeat (16)
				if (!enrolled[id])
					id = 4'($urandom_range(0, 15));
		push_item(MODE_REQUEST, id, 16'($urandom_range(0, 65535)),
			8'($urandom_range(0, 255)));
	endtask

	initial begin
		int span;
		int handed;
		int limit;
		int least_chunk;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_ENROLL;
		worker_id = '0;
		worker_power = '0;
		worker_load = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_TOTAL_ITERATIONS;
		cfg_data = '0;
		calm = 1'b0;
		sent = 0;
		requests_sent = 0;
		phases = 0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Out of reset: no shares yet, then a share but no iterations.
		push_item(MODE_REQUEST, 4'd0, 16'h0000, 8'h00);
		push_item(MODE_ENROLL, 4'd0, 16'h0000, 8'h00);
		push_item(MODE_REQUEST, 4'd0, 16'hFFFF, 8'hFF);
		push_item(MODE_REQUEST, 4'd5, 16'h0000, 8'h00);
		settle();

		write_reg(CFG_TOTAL_ITERATIONS, 16'd1000);
		write_reg(CFG_MIN_CHUNK, 16'd1);
		write_reg(CFG_USE_LOAD, 16'd1);
		push_item(MODE_ENROLL, 4'd15, 16'hFFFF, 8'h00);
		push_item(MODE_ENROLL, 4'd3, 16'h00FF, 8'h01);
		push_item(MODE_REQUEST, 4'd3, 16'h0000, 8'h00);
		push_item(MODE_REQUEST, 4'd15, 16'h0000, 8'h00);
		push_item(MODE_ENROLL, 4'd3, 16'hFFFF, 8'hFF);
		push_item(MODE_REQUEST, 4'd3, 16'h0000, 8'h00);
		push_item(MODE_ENROLL, 4'd7, 16'h8000, 8'h80);
		push_item(MODE_REQUEST, 4'd7, 16'h0000, 8'h00);
		push_item(MODE_REQUEST, 4'd0, 16'h0000, 8'h00);
		settle();

		// A floor above what remains hands everything out in one piece.
		write_reg(CFG_USE_LOAD, 16'd0);
		write_reg(CFG_MIN_CHUNK, 16'hFFFF);
		write_reg(CFG_TOTAL_ITERATIONS, handed_out + 16'd300);
		push_item(MODE_REQUEST, 4'd15, 16'h0000, 8'h00);
		push_item(MODE_REQUEST, 4'd0, 16'h0000, 8'h00);
		settle();

		write_reg(CFG_MIN_CHUNK, 16'd0);
		write_reg(CFG_TOTAL_ITERATIONS, handed_out + 16'd100);
		push_item(MODE_ENROLL, 4'd9, 16'h1234, 8'h02);
		push_item(MODE_REQUEST, 4'd9, 16'h0000, 8'h00);
		push_item(MODE_REQUEST, 4'd9, 16'h0000, 8'h00);

		while (sent < ITEM_TARGET) begin
			settle();
			phases++;
			calm = ($urandom_range(0, 3) == 0);
			span = $urandom_range(30, 90);
			handed = handed_out;
			case ($urandom_range(0, 9))
				0:       least_chunk = 0;
				1:       least_chunk = 65535;
				2:       least_chunk = $urandom_range(0, 65535);
				3, 4:    least_chunk = 1;
				default: least_chunk = $urandom_range(2, 8);
			endcase
			case ($urandom_range(0, 9))
				0:       limit = (handed > 0) ? $urandom_range(0, handed - 1) : 0;
				1:       limit = 0;
				default: limit = handed + $urandom_range(20, 600);
			endcase
			if (sent + span >= ITEM_TARGET)
				limit = 65535;
			if (limit > 65535)
				limit = 65535;
			write_reg(CFG_USE_LOAD, 16'($urandom_range(0, 1)));
			write_reg(CFG_MIN_CHUNK, 16'(least_chunk));
			write_reg(CFG_TOTAL_ITERATIONS, 16'(limit));
			repeat ($urandom_range(1, 4))
				enroll_random();
			repeat (span)
				if ($urandom_range(0, 9) == 0)
					enroll_random();
				else
					request_random();
		end
		settle();

		$display("Sent %0d transactions (%0d requests) over %0d random phases; %0d results checked.",
			sent, requests_sent, phases, results_seen);
		$display("Covered plain and load-aware modes, zero and full minimum chunks, shrunk totals.");
		if (mismatches == 0 && outstanding == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/gssc_pkg.sv
hw/rtl/gssc_div.sv
hw/rtl/gssc_seq.sv
hw/rtl/gssc_dp.sv
hw/rtl/guided_self_scheduling_chunker.sv
hw/rtl/gssc_checker.sv
test/chunk_grant_checker.sv
test/tb_guided_self_scheduling_chunker.sv
